[design/cbct_pkg.sv]
// Shared types and constants of the color blob centroid tracker.
`default_nettype none

package cbct_pkg;

	// Field and state widths
	localparam int CH_W    = 8;
	localparam int COORD_W = 11;
	localparam int OUT_W   = 12;
	localparam int SUM_W   = 34;
	localparam int CNT_W   = 23;
	localparam int IDX_W   = 3;

	// Frame limits and box geometry
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int BOX_SIZE   = 24;
	localparam logic [OUT_W-1:0] BOX_HALF = OUT_W'(BOX_SIZE / 2);

	// Saturation point of the match counter
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Divider: the mean always fits the coordinate width
	localparam int QUO_W  = COORD_W;
	localparam int REM_W  = SUM_W - QUO_W;
	localparam int STEP_W = $clog2(QUO_W);

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_BLUE_LOW   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GREEN_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_RED_LOW    = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLUE_HIGH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_GREEN_HIGH = 3'd4;
	localparam logic [IDX_W-1:0] REG_RED_HIGH   = 3'd5;

	// Reset values of the bounds
	localparam logic [CH_W-1:0] RST_BLUE_LOW   = 8'd0;
	localparam logic [CH_W-1:0] RST_GREEN_LOW  = 8'd200;
	localparam logic [CH_W-1:0] RST_RED_LOW    = 8'd0;
	localparam logic [CH_W-1:0] RST_BLUE_HIGH  = 8'd100;
	localparam logic [CH_W-1:0] RST_GREEN_HIGH = 8'd255;
	localparam logic [CH_W-1:0] RST_RED_HIGH   = 8'd100;

	typedef struct packed {
		logic [CH_W-1:0] blue_low;
		logic [CH_W-1:0] green_low;
		logic [CH_W-1:0] red_low;
		logic [CH_W-1:0] blue_high;
		logic [CH_W-1:0] green_high;
		logic [CH_W-1:0] red_high;
	} bounds_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_START,
		ST_DIVX,
		ST_DIVY,
		ST_LOAD
	} state_t;

endpackage

`default_nettype wire

[design/cbct_accum.sv]
// Color threshold test and centroid accumulators.
`default_nettype none

module cbct_accum (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cbct_pkg::bounds_t               bounds,
	input  wire logic                            take,
	input  wire logic                            clear,
	input  wire logic [cbct_pkg::CH_W-1:0]       blue,
	input  wire logic [cbct_pkg::CH_W-1:0]       green,
	input  wire logic [cbct_pkg::CH_W-1:0]       red,
	input  wire logic [cbct_pkg::COORD_W-1:0]    column,
	input  wire logic [cbct_pkg::COORD_W-1:0]    row,
	output logic      [cbct_pkg::SUM_W-1:0]      column_sum,
	output logic      [cbct_pkg::SUM_W-1:0]      row_sum,
	output logic      [cbct_pkg::CNT_W-1:0]      match_count
);
	import cbct_pkg::*;

	logic [SUM_W-1:0] col_sum_q;
	logic [SUM_W-1:0] row_sum_q;
	logic [CNT_W-1:0] count_q;
	logic             hit;

	// Test every channel against its bounds, the frame limits and the count ceiling
	always_comb begin
		hit = (blue >= bounds.blue_low) && (blue <= bounds.blue_high) &&
			(green >= bounds.green_low) && (green <= bounds.green_high) &&
			(red >= bounds.red_low) && (red <= bounds.red_high) &&
			(32'(column) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT) &&
			(count_q != COUNT_MAX);
	end

	// Accumulate matching pixels; drop everything once the frame result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_sum_q <= '0;
			row_sum_q <= '0;
			count_q   <= '0;
		end else if (clear) begin
			col_sum_q <= '0;
			row_sum_q <= '0;
			count_q   <= '0;
		end else if (take && hit) begin
			col_sum_q <= col_sum_q + SUM_W'(column);
			row_sum_q <= row_sum_q + SUM_W'(row);
			count_q   <= count_q + 1'b1;
		end
	end

	assign column_sum  = col_sum_q;
	assign row_sum     = row_sum_q;
	assign match_count = count_q;

endmodule

`default_nettype wire

[design/cbct_div.sv]
// Restoring divider producing one quotient bit per cycle.
`default_nettype none

module cbct_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cbct_pkg::SUM_W-1:0]    dividend,
	input  wire logic [cbct_pkg::CNT_W-1:0]    divisor,
	output logic                               done,
	output logic      [cbct_pkg::QUO_W-1:0]    quotient
);
	import cbct_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  qd_q;
	logic [REM_W+1:0]  trial;
	logic              fit;
	logic [REM_W-1:0]  rem_next;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial    = {1'b0, rem_q, qd_q[QUO_W-1]} - (REM_W+2)'(divisor);
		fit      = !trial[REM_W+1];
		rem_next = fit ? trial[REM_W-1:0] : {rem_q[REM_W-2:0], qd_q[QUO_W-1]};
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Load the upper bits as remainder, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:QUO_W];
			qd_q  <= dividend[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_next;
			qd_q  <= {qd_q[QUO_W-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

`default_nettype wire

[design/color_blob_centroid_tracker_unit.sv]
// Top level of the color blob centroid tracker: sequencer, registers and output stage.
`default_nettype none

// Pixels are taken one per cycle while the input is not stalled. A pixel that
// carries frame_end closes the frame. The block then stalls its input through
// one start state, 11 divider steps plus a hand-off for the mean column and again
// for the mean row, then one load state. A single shared restoring divider, one
// quotient bit per cycle, forms both means, and the result is loaded into the
// output register. A frame with no matching pixel skips the divider and goes
// from the start state straight to the load state. The output register holds a
// result until it is taken. Pixels of the next frame are accepted meanwhile.
// Only the next frame end waits for the register to free up, and it stalls the
// input for as long as it waits.
// Bounds are written through the cfg port.
module color_blob_centroid_tracker_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [cbct_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [cbct_pkg::CH_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [cbct_pkg::CH_W-1:0]         blue,
	input  wire logic [cbct_pkg::CH_W-1:0]         green,
	input  wire logic [cbct_pkg::CH_W-1:0]         red,
	input  wire logic [cbct_pkg::COORD_W-1:0]      column,
	input  wire logic [cbct_pkg::COORD_W-1:0]      row,
	input  wire logic                              frame_end,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   target_found,
	output logic      [cbct_pkg::COORD_W-1:0]      center_x,
	output logic      [cbct_pkg::COORD_W-1:0]      center_y,
	output logic signed [cbct_pkg::OUT_W-1:0]      box_left,
	output logic signed [cbct_pkg::OUT_W-1:0]      box_top,
	output logic signed [cbct_pkg::OUT_W-1:0]      move_x,
	output logic signed [cbct_pkg::OUT_W-1:0]      move_y
);
	import cbct_pkg::*;

	state_t             state_q, state_d;
	bounds_t            bounds_q;
	logic               take;
	logic               acc_clear;
	logic               div_start;
	logic               sel_row;
	logic               cap_x;
	logic               load_out;
	logic               out_free;
	logic [SUM_W-1:0]   column_sum;
	logic [SUM_W-1:0]   row_sum;
	logic [CNT_W-1:0]   match_count;
	logic [SUM_W-1:0]   dividend;
	logic               div_done;
	logic [QUO_W-1:0]   quotient;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] prev_x_q;
	logic [COORD_W-1:0] prev_y_q;
	logic               found;
	logic [COORD_W-1:0] cx_sel;
	logic [COORD_W-1:0] cy_sel;
	logic               out_valid_q;
	logic               found_q;
	logic [COORD_W-1:0] center_x_q;
	logic [COORD_W-1:0] center_y_q;
	logic [OUT_W-1:0]   box_left_q;
	logic [OUT_W-1:0]   box_top_q;
	logic [OUT_W-1:0]   move_x_q;
	logic [OUT_W-1:0]   move_y_q;

	// Bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q.blue_low   <= RST_BLUE_LOW;
			bounds_q.green_low  <= RST_GREEN_LOW;
			bounds_q.red_low    <= RST_RED_LOW;
			bounds_q.blue_high  <= RST_BLUE_HIGH;
			bounds_q.green_high <= RST_GREEN_HIGH;
			bounds_q.red_high   <= RST_RED_HIGH;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BLUE_LOW:   bounds_q.blue_low   <= cfg_data;
				REG_GREEN_LOW:  bounds_q.green_low  <= cfg_data;
				REG_RED_LOW:    bounds_q.red_low    <= cfg_data;
				REG_BLUE_HIGH:  bounds_q.blue_high  <= cfg_data;
				REG_GREEN_HIGH: bounds_q.green_high <= cfg_data;
				REG_RED_HIGH:   bounds_q.red_high   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign take     = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	cbct_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.bounds      (bounds_q),
		.take        (take),
		.clear       (acc_clear),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.column      (column),
		.row         (row),
		.column_sum  (column_sum),
		.row_sum     (row_sum),
		.match_count (match_count)
	);

	assign dividend = sel_row ? row_sum : column_sum;

	cbct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (match_count),
		.done     (div_done),
		.quotient (quotient)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer controls
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		sel_row   = 1'b0;
		cap_x     = 1'b0;
		load_out  = 1'b0;
		acc_clear = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_stall = 1'b0;
				if (in_valid && frame_end) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (match_count == '0) begin
					state_d = ST_LOAD;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIVX;
				end
			end
			ST_DIVX: begin
				if (div_done) begin
					cap_x     = 1'b1;
					div_start = 1'b1;
					sel_row   = 1'b1;
					state_d   = ST_DIVY;
				end
			end
			ST_DIVY: begin
				if (div_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					load_out  = 1'b1;
					acc_clear = 1'b1;
					state_d   = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	// Hold the mean column while the divider works on the row
	always_ff @(posedge clk) begin
		if (cap_x) begin
			cx_q <= quotient;
		end
	end

	// Pick the new centroid, or keep the previous one when the target is lost
	always_comb begin
		found  = (match_count != '0);
		cx_sel = found ? cx_q : prev_x_q;
		cy_sel = found ? quotient : prev_y_q;
	end

	// Previous centroid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (load_out && found) begin
			prev_x_q <= cx_sel;
			prev_y_q <= cy_sel;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: box corner and movement
	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q    <= found;
			center_x_q <= cx_sel;
			center_y_q <= cy_sel;
			box_left_q <= OUT_W'(cx_sel) - BOX_HALF;
			box_top_q  <= OUT_W'(cy_sel) - BOX_HALF;
			if (found && (prev_x_q != '0) && (prev_y_q != '0)) begin
				move_x_q <= OUT_W'(cx_sel) - OUT_W'(prev_x_q);
				move_y_q <= OUT_W'(cy_sel) - OUT_W'(prev_y_q);
			end else begin
				move_x_q <= '0;
				move_y_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign target_found = found_q;
	assign center_x     = center_x_q;
	assign center_y     = center_y_q;
	assign box_left     = box_left_q;
	assign box_top      = box_top_q;
	assign move_x       = move_x_q;
	assign move_y       = move_y_q;

endmodule

`default_nettype wire

[design/cbct_checker.sv]
// Port-level assertions of the tracker and the bind that attaches them.
`default_nettype none

module cbct_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              frame_end,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic                              target_found,
	input  wire logic [cbct_pkg::COORD_W-1:0]      center_x,
	input  wire logic [cbct_pkg::COORD_W-1:0]      center_y,
	input  wire logic signed [cbct_pkg::OUT_W-1:0] box_left,
	input  wire logic signed [cbct_pkg::OUT_W-1:0] box_top,
	input  wire logic signed [cbct_pkg::OUT_W-1:0] move_x,
	input  wire logic signed [cbct_pkg::OUT_W-1:0] move_y
);
	import cbct_pkg::*;

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A frame end item starts the centroid work, so input stalls next cycle
	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("input not stalled after frame end");

	// Box corner follows the centroid
	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (box_left == OUT_W'(OUT_W'(center_x) - BOX_HALF)) &&
			(box_top == OUT_W'(OUT_W'(center_y) - BOX_HALF)))
		else $error("box corner does not match centroid");

	// A lost target reports no movement
	a_lost_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !target_found |-> (move_x == '0) && (move_y == '0))
		else $error("movement reported for lost target");

endmodule

bind color_blob_centroid_tracker_unit cbct_checker u_cbct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.frame_end    (frame_end),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.target_found (target_found),
	.center_x     (center_x),
	.center_y     (center_y),
	.box_left     (box_left),
	.box_top      (box_top),
	.move_x       (move_x),
	.move_y       (move_y)
);

`default_nettype wire

[test/centroid_checker.sv]
// Checker of the color blob centroid tracker: mirrors the bounds, predicts each frame result and compares it.
`default_nettype none

module centroid_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [cbct_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [cbct_pkg::CH_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic [cbct_pkg::CH_W-1:0]           blue,
	input  wire logic [cbct_pkg::CH_W-1:0]           green,
	input  wire logic [cbct_pkg::CH_W-1:0]           red,
	input  wire logic [cbct_pkg::COORD_W-1:0]        column,
	input  wire logic [cbct_pkg::COORD_W-1:0]        row,
	input  wire logic                                frame_end,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic                                target_found,
	input  wire logic [cbct_pkg::COORD_W-1:0]        center_x,
	input  wire logic [cbct_pkg::COORD_W-1:0]        center_y,
	input  wire logic signed [cbct_pkg::OUT_W-1:0]   box_left,
	input  wire logic signed [cbct_pkg::OUT_W-1:0]   box_top,
	input  wire logic signed [cbct_pkg::OUT_W-1:0]   move_x,
	input  wire logic signed [cbct_pkg::OUT_W-1:0]   move_y,
	output int                                       pending,
	output int                                       mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import cbct_pkg::*;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [OUT_W-1:0]   box_x;
		logic [OUT_W-1:0]   box_y;
		logic [OUT_W-1:0]   mx;
		logic [OUT_W-1:0]   my;
	} centroid_t;

	// Mirror of the block's bounds and frame accumulators
	bounds_t            limits;
	logic [SUM_W-1:0]   col_acc;
	logic [SUM_W-1:0]   row_acc;
	logic [CNT_W-1:0]   hits;
	logic [COORD_W-1:0] last_cx;
	logic [COORD_W-1:0] last_cy;
	centroid_t          expected_centroids[$];

	function automatic bit in_range(input logic [CH_W-1:0] v, lo, hi);
		return v >= lo && v <= hi;
	endfunction

	function automatic void check_field(input string name,
			input logic signed [31:0] want, input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		centroid_t want;
		centroid_t got;
		bit        match;
		if (!arst_n) begin
			limits = {RST_BLUE_LOW, RST_GREEN_LOW, RST_RED_LOW,
				RST_BLUE_HIGH, RST_GREEN_HIGH, RST_RED_HIGH};
			col_acc = '0;
			row_acc = '0;
			hits = '0;
			last_cx = '0;
			last_cy = '0;
			expected_centroids.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// Follow bound writes; spare indexes change nothing
			if (cfg_write === 1'b1) begin
				case (cfg_index)
					REG_BLUE_LOW:   limits.blue_low = cfg_data;
					REG_GREEN_LOW:  limits.green_low = cfg_data;
					REG_RED_LOW:    limits.red_low = cfg_data;
					REG_BLUE_HIGH:  limits.blue_high = cfg_data;
					REG_GREEN_HIGH: limits.green_high = cfg_data;
					REG_RED_HIGH:   limits.red_high = cfg_data;
					default: ;
				endcase
			end

			// Compare a taken result with the oldest frame waiting
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = {target_found, center_x, center_y, box_left, box_top, move_x, move_y};
				if (expected_centroids.size() == 0) begin
					$error("result with no frame pending: found %0b center %0d,%0d",
						target_found, center_x, center_y);
					mismatches++;
				end else begin
					want = expected_centroids.pop_front();
					check_field("target_found", want.found, got.found);
					check_field("center_x", want.cx, got.cx);
					check_field("center_y", want.cy, got.cy);
					check_field("box_left", $signed(want.box_x), $signed(got.box_x));
					check_field("box_top", $signed(want.box_y), $signed(got.box_y));
					check_field("move_x", $signed(want.mx), $signed(got.mx));
					check_field("move_y", $signed(want.my), $signed(got.my));
				end
			end

			// Accumulate a taken pixel; close the frame on its last pixel
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				match = in_range(blue, limits.blue_low, limits.blue_high) &&
					in_range(green, limits.green_low, limits.green_high) &&
					in_range(red, limits.red_low, limits.red_high) &&
					int'(column) < MAX_WIDTH && int'(row) < MAX_HEIGHT &&
					hits != COUNT_MAX;
				if (match) begin
					col_acc += SUM_W'(column);
					row_acc += SUM_W'(row);
					hits++;
				end
				if (frame_end) begin
					if (hits != '0) begin
						want.found = 1'b1;
						want.cx = COORD_W'(col_acc / hits);
						want.cy = COORD_W'(row_acc / hits);
						// Movement only once a full previous centroid exists
						if (last_cx != '0 && last_cy != '0) begin
							want.mx = OUT_W'(want.cx) - OUT_W'(last_cx);
							want.my = OUT_W'(want.cy) - OUT_W'(last_cy);
						end else begin
							want.mx = '0;
							want.my = '0;
						end
						last_cx = want.cx;
						last_cy = want.cy;
					end else begin
						// Target lost: report the kept centroid, no movement
						want.found = 1'b0;
						want.cx = last_cx;
						want.cy = last_cy;
						want.mx = '0;
						want.my = '0;
					end
					want.box_x = OUT_W'(want.cx) - BOX_HALF;
					want.box_y = OUT_W'(want.cy) - BOX_HALF;
					expected_centroids.push_back(want);
					col_acc = '0;
					row_acc = '0;
					hits = '0;
				end
			end
			pending <= expected_centroids.size();
		end
	end

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench top of the color blob centroid tracker: clock, reset, pixel and bound stimulus, verdict.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbct_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int PHASE_PIXELS  = 235;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF      = 400;
	localparam int IDLE_LIMIT    = 2000;

	typedef enum int {SCATTER, CLUSTER, LEFT_EDGE, TOP_EDGE} spot_t;
	typedef enum int {
		PH_RESET_BOUNDS, PH_OPEN, PH_EMPTY_BLUE, PH_BACKLOG,
		PH_EXACT, PH_WILD, PH_RANDOM, PH_RESTORE
	} plan_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CH_W-1:0]           cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [CH_W-1:0]           blue = '0;
	logic [CH_W-1:0]           green = '0;
	logic [CH_W-1:0]           red = '0;
	logic [COORD_W-1:0]        column = '0;
	logic [COORD_W-1:0]        row = '0;
	logic                      frame_end = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      target_found;
	logic [COORD_W-1:0]        center_x;
	logic [COORD_W-1:0]        center_y;
	logic signed [OUT_W-1:0]   box_left;
	logic signed [OUT_W-1:0]   box_top;
	logic signed [OUT_W-1:0]   move_x;
	logic signed [OUT_W-1:0]   move_y;
	int                        results_due;
	int                        fail_count;

	bounds_t     cur_bounds = {RST_BLUE_LOW, RST_GREEN_LOW, RST_RED_LOW,
		RST_BLUE_HIGH, RST_GREEN_HIGH, RST_RED_HIGH};
	bit          calm = 1'b0;
	bit          long_hold = 1'b0;
	int unsigned pixels_sent = 0;

	always #2 clk = ~clk;

	color_blob_centroid_tracker_unit dut (.*);

	centroid_checker u_checker (
		.pending(results_due),
		.mismatches(fail_count),
		.*
	);

	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(6, 0);
	endfunction

	function automatic logic [CH_W-1:0] pick_channel(input logic [CH_W-1:0] lo, hi,
			input bit hit);
		if (hit && lo <= hi)
			return CH_W'($urandom_range(hi, lo));
		return CH_W'($urandom);
	endfunction

	function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c,
			input int spread);
		int v;
		v = int'(c) + int'($urandom_range(2 * spread, 0)) - spread;
		if (v < 0)
			v = 0;
		if (v > (1 << COORD_W) - 1)
			v = (1 << COORD_W) - 1;
		return COORD_W'(v);
	endfunction

	// Offer one pixel after a random gap and hold it until taken
	task automatic send_pixel(input logic [CH_W-1:0] b, g, r,
			input logic [COORD_W-1:0] c, rw, input logic fe);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		column <= c;
		row <= rw;
		frame_end <= fe;
		do @(posedge clk); while (in_stall !== 1'b0);
		pixels_sent++;
	endtask

	// One frame: pixels placed by a random pattern, most colors inside the bounds
	task automatic send_frame(input int unsigned n_px);
		spot_t              spot;
		logic [COORD_W-1:0] cx0;
		logic [COORD_W-1:0] cy0;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] rw;
		int                 spread;
		bit                 hit;
		spot = spot_t'($urandom_range(3, 0));
		cx0 = COORD_W'($urandom);
		cy0 = COORD_W'($urandom);
		spread = $urandom_range(60, 1);
		for (int unsigned i = 0; i < n_px; i++) begin
			case (spot)
				SCATTER: begin
					c = COORD_W'($urandom);
					rw = COORD_W'($urandom);
				end
				CLUSTER: begin
					c = near(cx0, spread);
					rw = near(cy0, spread);
				end
				LEFT_EDGE: begin
					c = '0;
					rw = near(cy0, spread);
				end
				default: begin
					c = near(cx0, spread);
					rw = '0;
				end
			endcase
			hit = $urandom_range(99, 0) < 60;
			send_pixel(pick_channel(cur_bounds.blue_low, cur_bounds.blue_high, hit),
				pick_channel(cur_bounds.green_low, cur_bounds.green_high, hit),
				pick_channel(cur_bounds.red_low, cur_bounds.red_high, hit),
				c, rw, i == n_px - 1);
		end
	endtask

	// Write all six bounds back to back, then both spare indexes
	task automatic apply_bounds(input bounds_t bnd);
		logic [IDX_W-1:0] regs [8];
		logic [CH_W-1:0]  vals [8];
		regs = '{REG_BLUE_LOW, REG_GREEN_LOW, REG_RED_LOW, REG_BLUE_HIGH,
			REG_GREEN_HIGH, REG_RED_HIGH, REG_SPARE_LO, REG_SPARE_HI};
		vals = '{bnd.blue_low, bnd.green_low, bnd.red_low, bnd.blue_high,
			bnd.green_high, bnd.red_high, CH_W'($urandom), CH_W'($urandom)};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		cur_bounds = bnd;
	endtask

	// Stop offering and wait for every result due; optionally let the block go quiet
	task automatic settle(input bit pause);
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		if (pause)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stall per result, one long hold-off on request
	initial begin : take_results
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				hold = HOLD_OFF;
			end else begin
				hold = draw_wait();
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				do @(posedge clk); while (out_valid !== 1'b1);
				repeat (hold - 1) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Watchdog: end the run when no item moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		plan_t       plan;
		bounds_t     bnd;
		int unsigned start;
		int unsigned n_px;
		logic [CH_W-1:0] lo;
		logic [CH_W-1:0] hi;
		logic [CH_W-1:0] tmp;
		bit          paused;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset bounds
		// lone unmatched pixel: target lost with no centroid yet
		send_pixel(8'd0, 8'd0, 8'd0, 11'd5, 11'd5, 1'b1);
		// matches on column zero, inclusive channel limits, closing pixel unmatched
		send_pixel(8'd0, 8'd200, 8'd0, 11'd0, 11'd5, 1'b0);
		send_pixel(8'd100, 8'd255, 8'd100, 11'd0, 11'd10, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 11'd300, 11'd300, 1'b1);
		// corner coordinates; previous column was zero so no movement
		send_pixel(8'd50, 8'd230, 8'd50, 11'd2047, 11'd2047, 1'b0);
		send_pixel(8'd50, 8'd230, 8'd50, 11'd0, 11'd0, 1'b0);
		send_pixel(8'd50, 8'd230, 8'd50, 11'd1, 11'd1, 1'b1);
		// each channel one step outside, then a match at the far corner
		send_pixel(8'd101, 8'd230, 8'd50, 11'd10, 11'd10, 1'b0);
		send_pixel(8'd50, 8'd199, 8'd50, 11'd10, 11'd10, 1'b0);
		send_pixel(8'd50, 8'd230, 8'd101, 11'd10, 11'd10, 1'b0);
		send_pixel(8'd100, 8'd200, 8'd100, 11'd2047, 11'd2047, 1'b1);
		// largest negative and positive moves
		send_pixel(8'd20, 8'd220, 8'd20, 11'd1, 11'd1, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd0, 11'd2047, 11'd0, 1'b1);
		// previous row was zero so no movement, then target lost keeps it
		send_pixel(8'd0, 8'd255, 8'd0, 11'd5, 11'd5, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 11'd3, 11'd3, 1'b1);

		for (int p = 0; p < 8; p++) begin
			plan = plan_t'(p);
			if (plan != PH_RESET_BOUNDS) begin
				settle(1'b1);
				case (plan)
					PH_OPEN:
						bnd = {8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
					PH_EMPTY_BLUE:
						bnd = {8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255};
					PH_EXACT: begin
						tmp = CH_W'($urandom);
						bnd = {8'd0, 8'd255, tmp, 8'd0, 8'd255, tmp};
					end
					PH_RESTORE:
						bnd = {RST_BLUE_LOW, RST_GREEN_LOW, RST_RED_LOW,
							RST_BLUE_HIGH, RST_GREEN_HIGH, RST_RED_HIGH};
					default: begin
						// random bounds; the wild set may leave a channel empty
						for (int k = 0; k < 3; k++) begin
							lo = CH_W'($urandom);
							hi = CH_W'($urandom);
							if (plan != PH_WILD && lo > hi) begin
								tmp = lo;
								lo = hi;
								hi = tmp;
							end
							case (k)
								0: begin
									bnd.blue_low = lo;
									bnd.blue_high = hi;
								end
								1: begin
									bnd.green_low = lo;
									bnd.green_high = hi;
								end
								default: begin
									bnd.red_low = lo;
									bnd.red_high = hi;
								end
							endcase
						end
					end
				endcase
				apply_bounds(bnd);
			end

			calm = plan == PH_EMPTY_BLUE || plan == PH_BACKLOG;
			if (plan == PH_BACKLOG)
				long_hold = 1'b1;
			paused = 1'b0;
			start = pixels_sent;
			while (pixels_sent - start < PHASE_PIXELS) begin
				if (plan == PH_BACKLOG)
					n_px = $urandom_range(3, 1);
				else if ($urandom_range(9, 0) == 0)
					n_px = $urandom_range(64, 17);
				else
					n_px = $urandom_range(16, 1);
				if (plan == PH_RANDOM)
					calm = $urandom_range(1, 0) != 0;
				send_frame(n_px);
				// hold the pixel stream until every result so far is out
				if (plan == PH_EXACT && !paused && pixels_sent - start >= PHASE_PIXELS / 2) begin
					paused = 1'b1;
					settle(1'b0);
				end
			end
		end

		settle(1'b1);
		if (fail_count == 0 && results_due == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
